>>> hw/rtl/nfsa_pkg.sv
package nfsa_pkg;

  localparam int POOL_SLOTS_DEF = 64;

  localparam int SLOT_NUM_W = 7;
  localparam int GRANT_W    = 6;
  localparam int USED_W     = 7;

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  typedef struct packed {
    logic                  command;
    logic [SLOT_NUM_W-1:0] slot_number;
  } req_t;

  typedef struct packed {
    logic               ok;
    logic [GRANT_W-1:0] granted_slot;
    logic [USED_W-1:0]  used_slots;
  } res_t;

  // Controls seen by a cell of the ring. Only the head cell gets set and clear.
  typedef struct packed {
    logic shift;
    logic set;
    logic clr;
  } cell_ctl_t;

endpackage

>>> hw/rtl/next_fit_slot_allocator_core.sv
// A failed beat (pool full, slot out of range) strobes done in the cycle after acceptance.
// A release rotates the ring until the slot reaches the head, then clears it and strobes done.
// An allocate rotates the ring to the search position, then one slot per cycle to a free one.
// One beat at a time; busy is high while the ring rotates.
// A new beat is accepted at the edge that takes the previous result; the receiver cannot stall.
// Synchronous reset frees every slot and clears the count, head and search position.
module next_fit_slot_allocator_core import nfsa_pkg::*; #(
  parameter int POOL_SLOTS = POOL_SLOTS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t request,
  output logic busy,
  output logic done,
  output res_t result
);

  localparam int SLOT_W = $clog2(POOL_SLOTS);
  localparam int CNT_W  = $clog2(POOL_SLOTS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SEEK = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;

  logic [1:0]        state, state_next;
  logic [SLOT_W-1:0] head, head_next, head_inc;
  logic [SLOT_W-1:0] target, target_next;
  logic [SLOT_W-1:0] srch, srch_next;
  logic [CNT_W-1:0]  count, count_next;
  logic              op, op_next;
  logic              emit;
  res_t              res_next;
  cell_ctl_t         ctl0, ctl_rest;
  logic              shift;
  logic [POOL_SLOTS-1:0] marks;

  // The ring rotates toward the head: cell 0 always holds the mark of slot head.
  assign ctl_rest = '{shift: shift, set: 1'b0, clr: 1'b0};

  for (genvar i = 0; i < POOL_SLOTS; i++) begin : g_cell
    nfsa_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .ctl  ((i == 0) ? ctl0 : ctl_rest),
      .nbr  (marks[(i + 1) % POOL_SLOTS]),
      .mark (marks[i])
    );
  end

  assign head_inc = (head == SLOT_W'(POOL_SLOTS - 1)) ? '0 : head + SLOT_W'(1);
  assign busy     = (state != ST_IDLE);

  always_comb begin
    state_next  = state;
    head_next   = head;
    target_next = target;
    op_next     = op;
    srch_next   = srch;
    count_next  = count;
    ctl0        = '0;
    shift       = 1'b0;
    emit        = 1'b0;
    res_next    = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (request.command == CMD_ALLOC) begin
            if (count == CNT_W'(POOL_SLOTS)) begin
              emit                = 1'b1;
              res_next.used_slots = USED_W'(count);
            end else begin
              target_next = srch;
              op_next     = CMD_ALLOC;
              state_next  = ST_SEEK;
            end
          end else begin
            if (32'(request.slot_number) < POOL_SLOTS) begin
              target_next = SLOT_W'(request.slot_number);
              op_next     = CMD_RELEASE;
              state_next  = ST_SEEK;
            end else begin
              emit                = 1'b1;
              res_next.used_slots = USED_W'(count);
            end
          end
        end
      end
      ST_SEEK: begin
        if (head == target) begin
          if (op == CMD_RELEASE) begin
            ctl0.clr = 1'b1;
            // Releasing a slot that is already free leaves the count alone.
            if (marks[0]) begin
              count_next = count - CNT_W'(1);
            end
            emit                = 1'b1;
            res_next.ok         = 1'b1;
            res_next.used_slots = USED_W'(count_next);
            state_next          = ST_IDLE;
          end else begin
            state_next = ST_SCAN;
          end
        end else begin
          shift      = 1'b1;
          ctl0.shift = 1'b1;
          head_next  = head_inc;
        end
      end
      ST_SCAN: begin
        if (!marks[0]) begin
          ctl0.set              = 1'b1;
          count_next            = count + CNT_W'(1);
          srch_next             = head;
          emit                  = 1'b1;
          res_next.ok           = 1'b1;
          res_next.granted_slot = GRANT_W'(head);
          res_next.used_slots   = USED_W'(count_next);
          state_next            = ST_IDLE;
        end else begin
          shift      = 1'b1;
          ctl0.shift = 1'b1;
          head_next  = head_inc;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      head  <= '0;
      srch  <= '0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      srch  <= srch_next;
      count <= count_next;
      done  <= emit;
    end
  end

  always_ff @(posedge clk) begin
    target <= target_next;
    op     <= op_next;
    result <= res_next;
  end

  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(POOL_SLOTS))
    else $error("used count exceeds the pool");

  assert property (@(posedge clk) disable iff (rst) head <= SLOT_W'(POOL_SLOTS - 1))
    else $error("ring head outside the pool");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (count < CNT_W'(POOL_SLOTS)))
    else $error("scan running on a full pool");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && !marks[0]) |=> (marks[0] && done && result.ok && !busy))
    else $error("free slot found but not granted");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEEK && head == target && op == CMD_RELEASE) |=> (!marks[0] && done))
    else $error("release did not clear the slot");

endmodule

>>> hw/rtl/nfsa_cell.sv
module nfsa_cell import nfsa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  logic      nbr,
  output logic      mark
);

  always_ff @(posedge clk) begin
    if (rst) begin
      mark <= 1'b0;
    end else if (ctl.shift) begin
      mark <= nbr;
    end else if (ctl.set) begin
      mark <= 1'b1;
    end else if (ctl.clr) begin
      mark <= 1'b0;
    end
  end

endmodule

>>> tb/sv/next_fit_slot_allocator_core_tb.sv
module next_fit_slot_allocator_core_tb;
  import nfsa_pkg::*;

  localparam int POOL          = POOL_SLOTS_DEF;
  localparam int RANDOM_BEATS  = 1500;
  localparam int PHASE_BEATS   = 125;
  localparam int IDLE_PERCENT  = 37;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 2 * POOL + 8;
  localparam int NUM_ROWS      = 15;

  typedef struct packed {
    req_t req;
    logic pinned;
    res_t want;
  } row_t;

  // Rows marked pinned carry a hand-worked answer; the rest go through the predictor.
  localparam row_t DIRECTED [NUM_ROWS] = '{
    '{'{CMD_ALLOC,   7'd0},   1'b1, '{1'b1, 6'd0, 7'd1}},
    '{'{CMD_ALLOC,   7'd0},   1'b1, '{1'b1, 6'd1, 7'd2}},
    '{'{CMD_RELEASE, 7'd127}, 1'b1, '{1'b0, 6'd0, 7'd2}},
    '{'{CMD_RELEASE, 7'd64},  1'b1, '{1'b0, 6'd0, 7'd2}},
    '{'{CMD_RELEASE, 7'd63},  1'b1, '{1'b1, 6'd0, 7'd2}},
    '{'{CMD_RELEASE, 7'd0},   1'b1, '{1'b1, 6'd0, 7'd1}},
    '{'{CMD_RELEASE, 7'd0},   1'b1, '{1'b1, 6'd0, 7'd1}},
    '{'{CMD_ALLOC,   7'd127}, 1'b0, '0},
    '{'{CMD_ALLOC,   7'd0},   1'b0, '0},
    '{'{CMD_RELEASE, 7'd2},   1'b0, '0},
    '{'{CMD_ALLOC,   7'd85},  1'b0, '0},
    '{'{CMD_RELEASE, 7'd1},   1'b0, '0},
    '{'{CMD_RELEASE, 7'd3},   1'b0, '0},
    '{'{CMD_RELEASE, 7'd4},   1'b0, '0},
    '{'{CMD_ALLOC,   7'd42},  1'b0, '0}
  };

  logic clk;
  logic rst;
  logic start;
  req_t request;
  logic busy;
  logic done;
  res_t result;

  // Shadow of the pool, advanced once per accepted beat.
  bit          slot_used [POOL];
  int unsigned used_count;
  int unsigned scan_from;

  res_t        pending_results [$];
  bit          row_pinned;
  res_t        row_result;
  int unsigned fail_count;
  int unsigned cycle_count;

  next_fit_slot_allocator_core #(
    .POOL_SLOTS(POOL)
  ) uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .request(request),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic res_t allocate_or_release(req_t req);
    res_t        r;
    int unsigned pos;
    r = '0;
    if (req.command == CMD_ALLOC) begin
      if (used_count < POOL) begin
        pos = scan_from;
        for (int n = 0; n < POOL; n++) begin
          if (!slot_used[pos]) begin
            slot_used[pos] = 1'b1;
            used_count++;
            scan_from = pos;
            r.ok = 1'b1;
            r.granted_slot = GRANT_W'(pos);
            break;
          end
          pos = (pos + 1) % POOL;
        end
      end
    end else if (req.slot_number < POOL) begin
      // Freeing a slot that is already free still succeeds but leaves the count alone.
      if (slot_used[req.slot_number]) begin
        slot_used[req.slot_number] = 1'b0;
        used_count--;
      end
      r.ok = 1'b1;
    end
    r.used_slots = USED_W'(used_count);
    return r;
  endfunction

  // Must be called at a falling edge; returns at the rising edge that accepts the beat.
  task automatic send_beat(input req_t req, input bit may_idle, input bit pin,
                           input res_t pinned_res);
    while (may_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
      start <= 1'b0;
      @(negedge clk);
    end
    row_pinned = pin;
    row_result = pinned_res;
    start   <= 1'b1;
    request <= req;
    do @(posedge clk); while (busy);
  endtask

  always @(posedge clk) begin : check_results
    res_t want;
    if (!rst) begin
      if (done) begin
        if (pending_results.size() == 0) begin
          $error("result beat with nothing expected: ok=%0d granted_slot=%0d used_slots=%0d",
                 result.ok, result.granted_slot, result.used_slots);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (result.ok !== want.ok) begin
            $error("ok: expected %0d, got %0d", want.ok, result.ok);
            fail_count++;
          end
          if (result.granted_slot !== want.granted_slot) begin
            $error("granted_slot: expected %0d, got %0d", want.granted_slot,
                   result.granted_slot);
            fail_count++;
          end
          if (result.used_slots !== want.used_slots) begin
            $error("used_slots: expected %0d, got %0d", want.used_slots, result.used_slots);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        want = allocate_or_release(request);
        if (row_pinned) want = row_result;
        pending_results.push_back(want);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    req_t        req;
    bit          filling;
    int unsigned roll;
    int unsigned base;
    int unsigned waited;

    rst        = 1'b1;
    start      = 1'b0;
    request    = '0;
    row_pinned = 1'b0;
    row_result = '0;
    fail_count = 0;
    foreach (slot_used[i]) slot_used[i] = 1'b0;
    used_count = 0;
    scan_from  = 0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int r = 0; r < NUM_ROWS; r++) begin
      @(negedge clk);
      send_beat(DIRECTED[r].req, 1'b1, DIRECTED[r].pinned, DIRECTED[r].want);
    end

    // Phases alternate between filling the pool (so it runs full and wraps) and draining it.
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      @(negedge clk);
      filling = ((i / PHASE_BEATS) % 2) == 0;
      req.slot_number = SLOT_NUM_W'($urandom_range(0, 127));
      if ($urandom_range(0, 99) < (filling ? 85 : 15)) begin
        req.command = CMD_ALLOC;
      end else begin
        req.command = CMD_RELEASE;
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
          req.slot_number = SLOT_NUM_W'($urandom_range(POOL, 127));
        end else if (roll < 65 && used_count > 0) begin
          base = $urandom_range(0, POOL - 1);
          for (int k = 0; k < POOL; k++) begin
            if (slot_used[(base + k) % POOL]) begin
              req.slot_number = SLOT_NUM_W'((base + k) % POOL);
              break;
            end
          end
        end else begin
          req.slot_number = SLOT_NUM_W'($urandom_range(0, POOL - 1));
        end
      end
      send_beat(req, !(i >= 600 && i < 900), 1'b0, '0);
    end

    @(negedge clk);
    start <= 1'b0;

    waited = 0;
    while (pending_results.size() != 0 && waited < 4 * POOL + 16) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected result beats never arrived", pending_results.size());
      fail_count++;
    end

    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/nfsa_pkg.sv
hw/rtl/nfsa_cell.sv
hw/rtl/next_fit_slot_allocator_core.sv
tb/sv/next_fit_slot_allocator_core_tb.sv
